// File: hw/rtl/rcfi_pkg.sv
// Package for the ray / cone frustum intersection pipeline.
// Holds fixed-point constants, pipeline payload types and arithmetic helpers.
// Used by ray_cone_frustum_intersect_top; depends on nothing.
package rcfi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int CFG_BITS  = 31;
  // Quotient steps: a word shifted left by the fraction width.
  localparam int DIV_STEPS = WORD_BITS + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  // Root steps: two radicand bits per step, radicand held in DIV_STEPS bits.
  localparam int SQ_STEPS  = DIV_STEPS / 2;
  localparam int SQ_REM_W  = SQ_STEPS + 3;

  typedef logic signed [WORD_BITS-1:0]   word_t;
  typedef logic signed [2*WORD_BITS-1:0] prod_t;
  typedef logic signed [WORD_BITS+1:0]   sum_t;

  localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam prod_t RND  = (prod_t'(1) <<< FRAC_BITS) - prod_t'(1);

  typedef enum logic [1:0] {
    CFG_NEAR = 2'd0,
    CFG_FAR  = 2'd1,
    CFG_LEN  = 2'd2
  } cfg_idx_t;

  // Members are listed last field first, so the first field sits in the low bits.
  typedef struct packed {
    word_t tmax;
    word_t tmin;
    word_t dz;
    word_t dy;
    word_t dx;
    word_t oz;
    word_t oy;
    word_t ox;
  } ray_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] rem;
    logic [DIV_STEPS-1:0] num;
    logic [DIV_STEPS-1:0] quo;
  } div_st_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0]  rem;
    logic [DIV_STEPS-1:0] x;
    logic [SQ_STEPS-1:0]  root;
  } sq_st_t;

  typedef struct packed {
    ray_t   ray;
    word_t  a;
    word_t  b;
    logic   miss;
    sq_st_t sq;
  } sqp_t;

  typedef struct packed {
    ray_t                 ray;
    logic                 miss;
    logic [WORD_BITS-1:0] dm;
    logic                 neg1;
    logic                 neg2;
    div_st_t              d1;
    div_st_t              d2;
  } dvp_t;

  function automatic word_t sat_w(input prod_t v);
    if (v > prod_t'(WMAX)) begin
      return WMAX;
    end else if (v < prod_t'(WMIN)) begin
      return WMIN;
    end
    return v[WORD_BITS-1:0];
  endfunction

  // Product scaled back to the word: magnitude truncated, then saturated.
  function automatic word_t mul_fin(input prod_t p);
    prod_t adj;
    adj = p + (p[2*WORD_BITS-1] ? RND : prod_t'(0));
    return sat_w(adj >>> FRAC_BITS);
  endfunction

  function automatic logic [WORD_BITS-1:0] mag_w(input word_t v);
    return v[WORD_BITS-1] ? $unsigned(~v) + 1'b1 : $unsigned(v);
  endfunction

  function automatic word_t sat_mag(input logic neg, input logic [DIV_STEPS-1:0] q);
    if (neg) begin
      if (q > DIV_STEPS'($unsigned(WMIN))) begin
        return WMIN;
      end
      return $signed(~q[WORD_BITS-1:0] + 1'b1);
    end
    if (q > DIV_STEPS'($unsigned(WMAX))) begin
      return WMAX;
    end
    return $signed(q[WORD_BITS-1:0]);
  endfunction

  function automatic div_st_t div_step(input div_st_t s, input logic [WORD_BITS-1:0] d);
    div_st_t           o;
    logic [WORD_BITS:0] r2;
    r2    = {s.rem, s.num[DIV_STEPS-1]};
    o.num = s.num << 1;
    if (r2 >= {1'b0, d}) begin
      o.rem = WORD_BITS'(r2 - {1'b0, d});
      o.quo = {s.quo[DIV_STEPS-2:0], 1'b1};
    end else begin
      o.rem = r2[WORD_BITS-1:0];
      o.quo = {s.quo[DIV_STEPS-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic sq_st_t sq_step(input sq_st_t s);
    sq_st_t              o;
    logic [SQ_REM_W+1:0] r4;
    logic [SQ_STEPS+1:0] trial;
    r4    = {s.rem, s.x[DIV_STEPS-1 -: 2]};
    trial = {s.root, 2'b01};
    o.x   = s.x << 2;
    if (r4 >= (SQ_REM_W+2)'(trial)) begin
      o.rem  = SQ_REM_W'(r4 - (SQ_REM_W+2)'(trial));
      o.root = {s.root[SQ_STEPS-2:0], 1'b1};
    end else begin
      o.rem  = SQ_REM_W'(r4);
      o.root = {s.root[SQ_STEPS-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// File: hw/rtl/ray_cone_frustum_intersect_top.sv
// Top level of the ray / cone frustum intersection pipeline.
// Depends on rcfi_pkg for types, constants and arithmetic helpers.
//
// Intersects one ray per beat, given in the shape's local frame (axis along y), with a cone
// frustum whose radius runs from near_radius at y = 0 to far_radius at y = axis_length. All
// values are signed Q16.16. The pipeline takes one ray in every cycle unless it is stalled or
// the slope is being worked out; its length is set by the 24-step square root and the two
// 48-step dividers that run as unrolled stages. One result beat comes out per ray: hit in
// out_tuser, and t and the hit point in out_tdata, all zero on a miss. The whole pipeline
// advances when the output register is empty or being taken, so a stall holds every stage.
// The slope of the cone is worked out by a bit-serial divider after reset and after every
// configuration write; while it runs, in_tready stays low.
module ray_cone_frustum_intersect_top
  import rcfi_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // Input rays. tdata from bit 0: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
  // t_min, t_max, 32 bits each.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [255:0] in_tdata,
  // Results. tuser: hit. tdata from bit 0: hit_t, hit_x, hit_y, hit_z, 32 bits each.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic         out_tuser,
  output logic [127:0] out_tdata,
  // Configuration writes.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  // ---------------------------------------------------------------------------------------
  // Configuration registers and the slope divider.
  // ---------------------------------------------------------------------------------------
  logic [CFG_BITS-1:0]  near_r, far_r, len_r;
  logic [CFG_BITS-1:0]  len_eff;
  word_t                r0_w, len_w, diff_w;
  logic                 cfg_acc;

  logic                 k_load_r, k_busy_r, k_neg_r;
  logic [DIV_CNT_W-1:0] k_cnt_r;
  div_st_t              k_st_r, k_st_nxt;
  word_t                k_r;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  // A zero axis length counts as one LSB.
  assign len_eff   = (len_r == '0) ? CFG_BITS'(1) : len_r;
  assign r0_w      = $signed({1'b0, near_r});
  assign len_w     = $signed({1'b0, len_eff});
  assign diff_w    = $signed({1'b0, far_r}) - $signed({1'b0, near_r});
  assign k_st_nxt  = div_step(k_st_r, $unsigned(len_w));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= CFG_BITS'(13107);
      far_r  <= CFG_BITS'(13107);
      len_r  <= CFG_BITS'(113512);
    end else if (cfg_acc) begin
      case (cfg_index)
        CFG_NEAR: near_r <= cfg_data[CFG_BITS-1:0];
        CFG_FAR:  far_r  <= cfg_data[CFG_BITS-1:0];
        CFG_LEN:  len_r  <= cfg_data[CFG_BITS-1:0];
        default:  ;
      endcase
    end
  end

  // The slope k = (far - near) / length is one quotient bit per cycle. A write restarts it
  // so that the next ray always sees the slope of the current registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_load_r <= 1'b1;
      k_busy_r <= 1'b0;
      k_cnt_r  <= '0;
    end else if (cfg_acc) begin
      k_load_r <= 1'b1;
      k_busy_r <= 1'b0;
    end else if (k_load_r) begin
      k_load_r <= 1'b0;
      k_busy_r <= 1'b1;
      k_cnt_r  <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (k_busy_r) begin
      k_cnt_r <= k_cnt_r - 1'b1;
      if (k_cnt_r == '0) begin
        k_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (k_load_r) begin
      k_st_r.rem <= '0;
      k_st_r.num <= {mag_w(diff_w), FRAC_BITS'(0)};
      k_st_r.quo <= '0;
      k_neg_r    <= diff_w[WORD_BITS-1];
    end else if (k_busy_r) begin
      k_st_r <= k_st_nxt;
      if (k_cnt_r == '0) begin
        k_r <= sat_mag(k_neg_r, k_st_nxt.quo);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Pipeline control: every stage moves when the output register can take a beat.
  // ---------------------------------------------------------------------------------------
  logic adv, in_acc, out_valid_r;
  ray_t ray_in;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv && !k_busy_r && !k_load_r;
  assign in_acc    = in_tvalid && in_tready;
  assign ray_in    = ray_t'(in_tdata);

  // Stage 1: products of the ray terms and the slope.
  logic  s1_v_r;
  ray_t  s1_ray_r;
  prod_t p_oyk_r, p_dyk_r, p_dxdx_r, p_dzdz_r, p_oxdx_r, p_ozdz_r, p_oxox_r, p_ozoz_r;

  // Stage 2: cone terms c0, c1 and the partial sums of A, B and C.
  logic  s2_v_r;
  ray_t  s2_ray_r;
  word_t c0_r, c1_r, c0_nxt;
  sum_t  sa_r, sb_r, sc_r;

  // Stage 3: products of the cone terms.
  logic  s3_v_r;
  ray_t  s3_ray_r;
  sum_t  s3_sa_r, s3_sb_r, s3_sc_r;
  prod_t p_c1c1_r, p_c0c1_r, p_c0c0_r;

  // Stage 4: the quadratic's coefficients.
  logic  s4_v_r;
  ray_t  s4_ray_r;
  word_t a_r, b_r, c_r, a_nxt, b_nxt, c_nxt, bh_nxt;

  // Stage 5: products for the discriminant.
  logic  s5_v_r;
  ray_t  s5_ray_r;
  word_t s5_a_r, s5_b_r;
  prod_t p_bb_r, p_ac_r;

  // Stage 6: discriminant, miss flag and the radicand for the root.
  logic  s6_v_r;
  sqp_t  s6_r, s6_nxt;
  word_t det_nxt, ac4_nxt;

  always_comb begin
    c0_nxt  = sat_w(prod_t'(r0_w) + prod_t'(mul_fin(p_oyk_r)));
    a_nxt   = sat_w(prod_t'(s3_sa_r) - prod_t'(mul_fin(p_c1c1_r)));
    bh_nxt  = sat_w(prod_t'(s3_sb_r) - prod_t'(mul_fin(p_c0c1_r)));
    b_nxt   = sat_w(prod_t'(bh_nxt) <<< 1);
    c_nxt   = sat_w(prod_t'(s3_sc_r) - prod_t'(mul_fin(p_c0c0_r)));
    ac4_nxt = sat_w(prod_t'(mul_fin(p_ac_r)) <<< 2);
    det_nxt = sat_w(prod_t'(mul_fin(p_bb_r)) - prod_t'(ac4_nxt));
    s6_nxt.ray     = s5_ray_r;
    s6_nxt.a       = s5_a_r;
    s6_nxt.b       = s5_b_r;
    s6_nxt.miss    = (det_nxt <= 0) || (s5_a_r == '0);
    s6_nxt.sq.rem  = '0;
    s6_nxt.sq.x    = {1'b0, det_nxt[WORD_BITS-2:0], FRAC_BITS'(0)};
    s6_nxt.sq.root = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ray_r <= ray_in;
      p_oyk_r  <= prod_t'(ray_in.oy) * prod_t'(k_r);
      p_dyk_r  <= prod_t'(ray_in.dy) * prod_t'(k_r);
      p_dxdx_r <= prod_t'(ray_in.dx) * prod_t'(ray_in.dx);
      p_dzdz_r <= prod_t'(ray_in.dz) * prod_t'(ray_in.dz);
      p_oxdx_r <= prod_t'(ray_in.ox) * prod_t'(ray_in.dx);
      p_ozdz_r <= prod_t'(ray_in.oz) * prod_t'(ray_in.dz);
      p_oxox_r <= prod_t'(ray_in.ox) * prod_t'(ray_in.ox);
      p_ozoz_r <= prod_t'(ray_in.oz) * prod_t'(ray_in.oz);

      s2_ray_r <= s1_ray_r;
      c0_r     <= c0_nxt;
      c1_r     <= mul_fin(p_dyk_r);
      sa_r     <= sum_t'(mul_fin(p_dxdx_r)) + sum_t'(mul_fin(p_dzdz_r));
      sb_r     <= sum_t'(mul_fin(p_oxdx_r)) + sum_t'(mul_fin(p_ozdz_r));
      sc_r     <= sum_t'(mul_fin(p_oxox_r)) + sum_t'(mul_fin(p_ozoz_r));

      s3_ray_r <= s2_ray_r;
      s3_sa_r  <= sa_r;
      s3_sb_r  <= sb_r;
      s3_sc_r  <= sc_r;
      p_c1c1_r <= prod_t'(c1_r) * prod_t'(c1_r);
      p_c0c1_r <= prod_t'(c0_r) * prod_t'(c1_r);
      p_c0c0_r <= prod_t'(c0_r) * prod_t'(c0_r);

      s4_ray_r <= s3_ray_r;
      a_r      <= a_nxt;
      b_r      <= b_nxt;
      c_r      <= c_nxt;

      s5_ray_r <= s4_ray_r;
      s5_a_r   <= a_r;
      s5_b_r   <= b_r;
      p_bb_r   <= prod_t'(b_r) * prod_t'(b_r);
      p_ac_r   <= prod_t'(a_r) * prod_t'(c_r);

      s6_r     <= s6_nxt;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Square root of the discriminant: one root bit per stage.
  // ---------------------------------------------------------------------------------------
  sqp_t                sq_in  [SQ_STEPS];
  sqp_t                sq_nxt [SQ_STEPS];
  sqp_t                sq_r   [SQ_STEPS];
  logic [SQ_STEPS-1:0] sq_v_r;

  always_comb begin
    sq_in[0] = s6_r;
    for (int i = 1; i < SQ_STEPS; i++) begin
      sq_in[i] = sq_r[i-1];
    end
    for (int i = 0; i < SQ_STEPS; i++) begin
      sq_nxt[i]    = sq_in[i];
      sq_nxt[i].sq = sq_step(sq_in[i].sq);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < SQ_STEPS; i++) begin
        sq_r[i] <= sq_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Root numerators and denominator, then two unrolled dividers.
  // ---------------------------------------------------------------------------------------
  logic                 n1_v_r;
  dvp_t                 n1_r, n1_nxt;
  word_t                den_nxt, num1_nxt, num2_nxt;
  dvp_t                 dv_in  [DIV_STEPS];
  dvp_t                 dv_nxt [DIV_STEPS];
  dvp_t                 dv_r   [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_v_r;
  sqp_t                 sq_last;

  assign sq_last = sq_r[SQ_STEPS-1];

  always_comb begin
    den_nxt  = sat_w(prod_t'(sq_last.a) <<< 1);
    num1_nxt = sat_w(-prod_t'(sq_last.b) - $signed({{WORD_BITS{1'b0}}, 8'd0, sq_last.sq.root}));
    num2_nxt = sat_w(-prod_t'(sq_last.b) + $signed({{WORD_BITS{1'b0}}, 8'd0, sq_last.sq.root}));
    n1_nxt.ray    = sq_last.ray;
    n1_nxt.miss   = sq_last.miss;
    n1_nxt.dm     = mag_w(den_nxt);
    n1_nxt.neg1   = num1_nxt[WORD_BITS-1] ^ den_nxt[WORD_BITS-1];
    n1_nxt.neg2   = num2_nxt[WORD_BITS-1] ^ den_nxt[WORD_BITS-1];
    n1_nxt.d1.rem = '0;
    n1_nxt.d1.num = {mag_w(num1_nxt), FRAC_BITS'(0)};
    n1_nxt.d1.quo = '0;
    n1_nxt.d2.rem = '0;
    n1_nxt.d2.num = {mag_w(num2_nxt), FRAC_BITS'(0)};
    n1_nxt.d2.quo = '0;

    dv_in[0] = n1_r;
    for (int i = 1; i < DIV_STEPS; i++) begin
      dv_in[i] = dv_r[i-1];
    end
    for (int i = 0; i < DIV_STEPS; i++) begin
      dv_nxt[i]    = dv_in[i];
      dv_nxt[i].d1 = div_step(dv_in[i].d1, dv_in[i].dm);
      dv_nxt[i].d2 = div_step(dv_in[i].d2, dv_in[i].dm);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n1_r <= n1_nxt;
      for (int i = 0; i < DIV_STEPS; i++) begin
        dv_r[i] <= dv_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Root ordering, hit points for both roots and the final choice.
  // ---------------------------------------------------------------------------------------
  dvp_t  dv_last;
  word_t t1_w, t2_w;

  logic  f1_v_r, f1_miss_r;
  ray_t  f1_ray_r;
  word_t t_lo_r, t_hi_r;

  logic  f2_v_r, f2_miss_r;
  ray_t  f2_ray_r;
  word_t f2_lo_r, f2_hi_r;
  prod_t p_xlo_r, p_ylo_r, p_zlo_r, p_xhi_r, p_yhi_r, p_zhi_r;

  logic  f3_v_r, f3_miss_r, in1_r, in2_r;
  word_t f3_lo_r, f3_hi_r;
  word_t px1_r, py1_r, pz1_r, px2_r, py2_r, pz2_r;

  logic  ok1, ok2, take1, hit_nxt;
  logic  out_hit_r;
  word_t out_t_r, out_x_r, out_y_r, out_z_r;

  assign dv_last = dv_r[DIV_STEPS-1];
  assign t1_w    = sat_mag(dv_last.neg1, dv_last.d1.quo);
  assign t2_w    = sat_mag(dv_last.neg2, dv_last.d2.quo);

  // The near root wins when it lies in the interval and inside the axial span; otherwise
  // the far root is taken under the same two tests.
  assign ok1     = !py1_r[WORD_BITS-1] && (py1_r <= len_w);
  assign ok2     = !py2_r[WORD_BITS-1] && (py2_r <= len_w);
  assign take1   = in1_r && ok1;
  assign hit_nxt = !f3_miss_r && (take1 || (in2_r && ok2));

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_ray_r  <= dv_last.ray;
      f1_miss_r <= dv_last.miss;
      t_lo_r    <= (t1_w > t2_w) ? t2_w : t1_w;
      t_hi_r    <= (t1_w > t2_w) ? t1_w : t2_w;

      f2_ray_r  <= f1_ray_r;
      f2_miss_r <= f1_miss_r;
      f2_lo_r   <= t_lo_r;
      f2_hi_r   <= t_hi_r;
      p_xlo_r   <= prod_t'(f1_ray_r.dx) * prod_t'(t_lo_r);
      p_ylo_r   <= prod_t'(f1_ray_r.dy) * prod_t'(t_lo_r);
      p_zlo_r   <= prod_t'(f1_ray_r.dz) * prod_t'(t_lo_r);
      p_xhi_r   <= prod_t'(f1_ray_r.dx) * prod_t'(t_hi_r);
      p_yhi_r   <= prod_t'(f1_ray_r.dy) * prod_t'(t_hi_r);
      p_zhi_r   <= prod_t'(f1_ray_r.dz) * prod_t'(t_hi_r);

      f3_miss_r <= f2_miss_r;
      f3_lo_r   <= f2_lo_r;
      f3_hi_r   <= f2_hi_r;
      in1_r     <= (f2_lo_r >= f2_ray_r.tmin) && (f2_lo_r <= f2_ray_r.tmax);
      in2_r     <= (f2_hi_r >= f2_ray_r.tmin) && (f2_hi_r <= f2_ray_r.tmax);
      px1_r     <= sat_w(prod_t'(f2_ray_r.ox) + prod_t'(mul_fin(p_xlo_r)));
      py1_r     <= sat_w(prod_t'(f2_ray_r.oy) + prod_t'(mul_fin(p_ylo_r)));
      pz1_r     <= sat_w(prod_t'(f2_ray_r.oz) + prod_t'(mul_fin(p_zlo_r)));
      px2_r     <= sat_w(prod_t'(f2_ray_r.ox) + prod_t'(mul_fin(p_xhi_r)));
      py2_r     <= sat_w(prod_t'(f2_ray_r.oy) + prod_t'(mul_fin(p_yhi_r)));
      pz2_r     <= sat_w(prod_t'(f2_ray_r.oz) + prod_t'(mul_fin(p_zhi_r)));

      // A miss sends all fields as zero.
      out_hit_r <= hit_nxt;
      out_t_r   <= !hit_nxt ? '0 : (take1 ? f3_lo_r : f3_hi_r);
      out_x_r   <= !hit_nxt ? '0 : (take1 ? px1_r : px2_r);
      out_y_r   <= !hit_nxt ? '0 : (take1 ? py1_r : py2_r);
      out_z_r   <= !hit_nxt ? '0 : (take1 ? pz1_r : pz2_r);
    end
  end

  // Valid bits travel alongside the payload and are the only pipeline state that resets.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      sq_v_r      <= '0;
      n1_v_r      <= 1'b0;
      dv_v_r      <= '0;
      f1_v_r      <= 1'b0;
      f2_v_r      <= 1'b0;
      f3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= in_acc;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      s5_v_r      <= s4_v_r;
      s6_v_r      <= s5_v_r;
      sq_v_r      <= {sq_v_r[SQ_STEPS-2:0], s6_v_r};
      n1_v_r      <= sq_v_r[SQ_STEPS-1];
      dv_v_r      <= {dv_v_r[DIV_STEPS-2:0], n1_v_r};
      f1_v_r      <= dv_v_r[DIV_STEPS-1];
      f2_v_r      <= f1_v_r;
      f3_v_r      <= f2_v_r;
      out_valid_r <= f3_v_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {out_z_r, out_y_r, out_x_r, out_t_r};

  // ---------------------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------------------
  a_no_ray_while_slope_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (k_busy_r || k_load_r) |-> !in_tready)
    else $error("ray accepted while the slope divider is busy");

  a_cfg_restarts_slope: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> (k_load_r && !in_tready))
    else $error("configuration write did not restart the slope divider");

  a_hit_inside_span: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> (!out_y_r[WORD_BITS-1] && (out_y_r <= len_w)))
    else $error("hit point lies outside the axial span");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit_r) |-> (out_tdata == '0))
    else $error("miss beat carries nonzero data");

  a_slope_done_count: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(k_busy_r) && !$past(cfg_acc) |-> ($past(k_cnt_r) == '0))
    else $error("slope divider finished before its last step");

endmodule

// File: dv/tb.sv
// Self-checking testbench for ray_cone_frustum_intersect_top.
// Streams rays through the block, predicts each result in fixed point and compares.
// Depends on rcfi_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;
  import rcfi_pkg::*;

  localparam int LATENCY = 83;
  localparam int N_RANDOM = 1900;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic hit;
    logic [31:0] t;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } hit_rec_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [255:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic out_tuser;
  logic [127:0] out_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  ray_cone_frustum_intersect_top uut (.*);

  // Shadow copy of the shape registers.
  longint shape_near = 13107, shape_far = 13107, shape_len = 113512;

  logic [255:0] ray_queue[$];
  hit_rec_t expected_hits[$];
  int n_errors = 0, n_mismatch = 0, n_hits = 0, n_results = 0;
  int send_idle = 0, recv_idle = 0; // percent
  longint cycles = 0;
  logic hold_sender = 0;

  initial forever #5 clk = ~clk;

  // ---------------- fixed-point predictor ----------------
  localparam longint W_MAX = 64'sd2147483647;
  localparam longint W_MIN = -64'sd2147483648;

  function automatic longint clamp_word(longint v);
    if (v > W_MAX) return W_MAX;
    if (v < W_MIN) return W_MIN;
    return v;
  endfunction

  // Sign-magnitude saturation of a wide magnitude.
  function automatic longint clamp_mag(bit neg, logic [127:0] m);
    if (neg) return (m > 128'd2147483648) ? W_MIN : -longint'(m[63:0]);
    return (m > 128'd2147483647) ? W_MAX : longint'(m[63:0]);
  endfunction

  function automatic logic [127:0] abs_val(longint v);
    return v < 0 ? 128'(-v) : 128'(v);
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic [127:0] p;
    p = abs_val(a) * abs_val(b);
    return clamp_mag((a < 0) != (b < 0), p >> FRAC_BITS);
  endfunction

  function automatic longint qdiv(longint n, longint d);
    logic [127:0] q;
    if (d == 0) return 0;
    q = (abs_val(n) << FRAC_BITS) / abs_val(d);
    return clamp_mag((n < 0) != (d < 0), q);
  endfunction

  function automatic longint qsqrt(longint v);
    logic [127:0] rad, r, c;
    rad = 128'(v) << FRAC_BITS;
    r = 0;
    for (int b = 40; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= rad) r = c;
    end
    return clamp_mag(0, r);
  endfunction

  function automatic hit_rec_t predict_hit(logic [255:0] ray);
    longint ox, oy, oz, dx, dy, dz, tmin, tmax, len, k, c0, c1, a, b, c, det, s, den;
    longint t1, t2, t, py;
    bit far_root;
    hit_rec_t r;
    r = '0;
    far_root = 0;
    ox = longint'($signed(ray[31:0]));    oy = longint'($signed(ray[63:32]));
    oz = longint'($signed(ray[95:64]));   dx = longint'($signed(ray[127:96]));
    dy = longint'($signed(ray[159:128])); dz = longint'($signed(ray[191:160]));
    tmin = longint'($signed(ray[223:192])); tmax = longint'($signed(ray[255:224]));
    len = shape_len == 0 ? 1 : shape_len;
    k = qdiv(shape_far - shape_near, len);
    c0 = clamp_word(shape_near + qmul(oy, k));
    c1 = qmul(dy, k);
    a = clamp_word(qmul(dx, dx) + qmul(dz, dz) - qmul(c1, c1));
    b = clamp_word(2 * clamp_word(qmul(ox, dx) + qmul(oz, dz) - qmul(c0, c1)));
    c = clamp_word(qmul(ox, ox) + qmul(oz, oz) - qmul(c0, c0));
    det = clamp_word(qmul(b, b) - clamp_word(4 * qmul(a, c)));
    if (det <= 0 || a == 0) return r;
    s = qsqrt(det);
    den = clamp_word(2 * a);
    t1 = qdiv(clamp_word(-b - s), den);
    t2 = qdiv(clamp_word(-b + s), den);
    if (t1 > t2) begin
      t = t1; t1 = t2; t2 = t;
    end
    t = t1;
    if (t < tmin || t > tmax) begin
      t = t2;
      if (t < tmin || t > tmax) return r;
      far_root = 1;
    end
    py = clamp_word(oy + qmul(dy, t));
    if (py < 0 || py > len) begin
      if (far_root) return r;
      t = t2;
      if (t < tmin || t > tmax) return r;
      py = clamp_word(oy + qmul(dy, t));
      if (py < 0 || py > len) return r;
    end
    r.hit = 1;
    r.t = t[31:0];
    r.x = 32'(clamp_word(ox + qmul(dx, t)));
    r.y = py[31:0];
    r.z = 32'(clamp_word(oz + qmul(dz, t)));
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic [255:0] pack_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                            int tmin, int tmax);
    return {tmax, tmin, dz, dy, dx, oz, oy, ox};
  endfunction

  // A ray aimed roughly at the frustum: origin off to the side, direction pointing
  // back across the axis, with small Q16.16 values so the quadratic stays in range.
  function automatic logic [255:0] aimed_ray();
    int ox, oy, oz, dx, dy, dz;
    ox = $urandom_range(0, 262144) - 131072;
    oz = $urandom_range(0, 262144) - 131072;
    oy = $urandom_range(0, 140000) - 10000;
    dx = -ox / 2 + int'($urandom_range(0, 20000)) - 10000;
    dz = -oz / 2 + int'($urandom_range(0, 20000)) - 10000;
    dy = $urandom_range(0, 40000) - 20000;
    return pack_ray(ox, oy, oz, dx, dy, dz, -int'($urandom_range(0, 65536)),
                    $urandom_range(0, 2000000));
  endfunction

  function automatic int edge_val();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (ray_queue.size() != 0 && !hold_sender && $urandom_range(0, 99) >= send_idle)
            begin
          in_tvalid <= 1'b1;
          in_tdata <= ray_queue[0];
          expected_hits.push_back(predict_hit(ray_queue[0]));
          void'(ray_queue.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    hit_rec_t want, got;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
             out_tdata[127:96]};
      n_results++;
      if (expected_hits.size() == 0) begin
        n_errors++;
        if (n_mismatch++ < 10) $display("Unexpected result beat: %h", got);
      end else begin
        want = expected_hits.pop_front();
        if (want.hit) n_hits++;
        if (got !== want) begin
          n_errors++;
          if (n_mismatch++ < 10)
            $display("Mismatch: hit %0b/%0b t %h/%h x %h/%h y %h/%h z %h/%h (exp/act)",
                     want.hit, got.hit, want.t, got.t, want.x, got.x, want.y, got.y,
                     want.z, got.z);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout with %0d results outstanding", expected_hits.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Writes one shape register; the block must be idle. The shadow copy follows.
  task automatic write_shape(cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_NEAR: shape_near = val[30:0];
      CFG_FAR:  shape_far = val[30:0];
      default:  shape_len = val[30:0];
    endcase
  endtask

  task automatic drain();
    while (ray_queue.size() != 0 || expected_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic load_random(int n);
    for (int i = 0; i < n; i++)
      if ($urandom_range(0, 99) < 80) ray_queue.push_back(aimed_ray());
      else ray_queue.push_back({$urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom});
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rays with the reset shape: axial hits, parallel rays, extremes.
    send_idle = 0; recv_idle = 0;
    ray_queue.push_back(pack_ray(-131072, 50000, 0, 65536, 0, 0, 0, 32'h7fffffff));
    ray_queue.push_back(pack_ray(-131072, 50000, 0, 65536, 0, 0, 0, 65536));
    ray_queue.push_back(pack_ray(-131072, 50000, 0, 65536, 0, 0, 1000000, 2000000));
    ray_queue.push_back(pack_ray(0, 50000, 0, 0, 65536, 0, 0, 32'h7fffffff));
    ray_queue.push_back(pack_ray(0, -65536, 0, 0, 0, 0, 0, 65536));
    ray_queue.push_back(pack_ray(0, 50000, -131072, 0, 0, 65536, -65536, 32'h7fffffff));
    ray_queue.push_back(pack_ray(-131072, 500000, 0, 65536, 0, 0, 0, 32'h7fffffff));
    ray_queue.push_back(pack_ray(0, 0, 0, 65536, 0, 0, 32'h80000000, 32'h7fffffff));
    ray_queue.push_back(pack_ray(0, 50000, 0, 65536, 0, 0, 32'h80000000, 32'h7fffffff));
    ray_queue.push_back({8{32'h7fffffff}});
    ray_queue.push_back({8{32'h80000000}});
    ray_queue.push_back('0);
    ray_queue.push_back({8{32'hffffffff}});
    for (int i = 0; i < 8; i++)
      ray_queue.push_back(pack_ray(edge_val(), edge_val(), edge_val(), edge_val(),
                                   edge_val(), edge_val(), edge_val(), edge_val()));
    drain();

    // Cone with a real slope, zero-radius apex, and extreme register settings.
    write_shape(CFG_NEAR, 0);
    write_shape(CFG_FAR, 32'd65536);
    write_shape(CFG_LEN, 32'd131072);
    send_idle = 29; recv_idle = 75;
    load_random(N_RANDOM / 3);
    drain();

    write_shape(CFG_NEAR, 32'h7fffffff);
    write_shape(CFG_FAR, 32'hffffffff);
    write_shape(CFG_LEN, 0);
    load_random(40);
    drain();

    write_shape(CFG_NEAR, 32'd98304);
    write_shape(CFG_FAR, 32'd16384);
    write_shape(CFG_LEN, 32'h7fffffff);
    send_idle = 75; recv_idle = 29;
    load_random(N_RANDOM / 3);
    // Hold the sender back until the pipeline has emptied, then resume.
    hold_sender = 1;
    load_random(20);
    while (expected_hits.size() != 0) @(posedge clk);
    hold_sender = 0;
    drain();

    write_shape(CFG_NEAR, 32'd13107);
    write_shape(CFG_FAR, 32'd40000);
    write_shape(CFG_LEN, 32'd113512);
    send_idle = 0; recv_idle = 0;
    load_random(N_RANDOM / 3);
    drain();

    $display("Checked %0d rays (%0d hits) over five shape settings and three idling mixes.",
             n_results, n_hits);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
